// ----- design/vtle_pkg.sv -----
// ----------------------------------------------------------------------------
// vtle_pkg
// shared types, constants and helpers of the linestring geometry encoder
// ----------------------------------------------------------------------------
package vtle_pkg;

	// default limits
	localparam int unsigned MaxPointsDefault  = 65536;
	localparam int unsigned QueueDepthDefault = 2;

	// fixed field widths
	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = 17;

	// geometry command and header codes
	localparam logic [WordW-1:0] CmdMoveToOne = 32'd9;
	localparam logic [2:0]       HdrLineTo    = 3'd2;

	// what the back end has to emit for one request
	typedef enum logic [1:0] {
		JOB_REJECT,
		JOB_FIRST,
		JOB_NEXT
	} job_kind_t;

	// one classified request travelling from front to back
	typedef struct packed {
		job_kind_t          kind;
		logic [WordW-1:0]   dx_zz;
		logic [WordW-1:0]   dy_zz;
		logic [CountW-1:0]  run;
	} job_t;

	// zigzag mapping of a two's complement delta
	function automatic logic [WordW-1:0] zigzag(input logic [WordW-1:0] d);
		return {d[WordW-2:0], 1'b0} ^ {WordW{d[WordW-1]}};
	endfunction

endpackage

// ----- design/vector_tile_linestring_encoder_top.sv -----
// ----------------------------------------------------------------------------
// vector_tile_linestring_encoder_top
// zigzag delta encoder for linestring geometry of tiled vector maps
// ----------------------------------------------------------------------------
// Points stream in one per request and leave as 32-bit geometry words: the
// opening point of a line gives MoveTo(1), zigzag dx, zigzag dy and the LineTo
// header, later points give zigzag dx and dy, and a refused point gives one
// zero word flagged in m_tuser. The front takes a point every cycle while its
// queue (two entries by default) has room, and the first word of a point is
// held in a queue slot and then registered onto m_tdata. Throughput is set by
// the single output word port, one word per cycle while m_tready allows it.
// The cursor is kept in the front, so a new-feature flag or a new line takes
// effect without any drain.
// ----------------------------------------------------------------------------
module vector_tile_linestring_encoder_top #(
	parameter int unsigned MAX_POINTS  = vtle_pkg::MaxPointsDefault,
	parameter int unsigned QUEUE_DEPTH = vtle_pkg::QueueDepthDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [87:0]  s_tdata,   // point_x, point_y, point_count, zero fill
	input  logic [1:0]   s_tuser,   // first_point, new_feature
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // geometry_word
	output logic         m_tlast,   // last_of_item
	output logic [0:0]   m_tuser    // rejected
);

	vtle_pkg::job_t push_job, head_job;
	logic           q_push, q_pop, q_full, q_empty;

	// front: cursor, classification, deltas
	vtle_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.point_x     (s_tdata[31:0]),
		.point_y     (s_tdata[63:32]),
		.point_count (s_tdata[80:64]),
		.first_point (s_tuser[0]),
		.new_feature (s_tuser[1]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	// request queue
	vtle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	// back: word serializer
	vtle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata),
		.out_last  (m_tlast),
		.out_rej   (m_tuser[0])
	);

`ifndef SYNTHESIS
	// a refused point is a single zero word closing its request
	a_reject_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("rejected word is not a lone zero word");

	// the back end never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// the front end never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");
`endif

endmodule

// ----- design/vtle_front.sv -----
// ----------------------------------------------------------------------------
// vtle_front
// accepts points, keeps the cursor and the open-line count, classifies each
// request and forms its zigzag deltas for the queue
// ----------------------------------------------------------------------------
module vtle_front #(
	parameter int unsigned MAX_POINTS = vtle_pkg::MaxPointsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [vtle_pkg::WordW-1:0]    point_x,
	input  logic [vtle_pkg::WordW-1:0]    point_y,
	input  logic [vtle_pkg::CountW-1:0]   point_count,
	input  logic                          first_point,
	input  logic                          new_feature,
	input  logic                          q_full,
	output logic                          q_push,
	output vtle_pkg::job_t                q_job
);

	localparam int unsigned CntW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

	logic [vtle_pkg::WordW-1:0] cursor_x_q, cursor_y_q;
	logic [CntW-1:0]            remain_q;

	logic [vtle_pkg::WordW-1:0] base_x, base_y, dx, dy;
	logic [31:0]                count_w, count_m1_w;
	logic                       bad_count, line_open;

	// handshake
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// cursor after an optional new-feature clear
	assign base_x = new_feature ? '0 : cursor_x_q;
	assign base_y = new_feature ? '0 : cursor_y_q;
	assign dx     = point_x - base_x;
	assign dy     = point_y - base_y;

	// point count checks
	assign count_w    = 32'(point_count);
	assign count_m1_w = count_w - 32'd1;
	assign bad_count  = (count_w < 32'd2) || (count_w > 32'(MAX_POINTS));
	assign line_open  = (remain_q != '0);

	// classify the request
	always_comb begin
		q_job.dx_zz = vtle_pkg::zigzag(dx);
		q_job.dy_zz = vtle_pkg::zigzag(dy);
		q_job.run   = count_m1_w[vtle_pkg::CountW-1:0];
		priority if (first_point) begin
			q_job.kind = bad_count ? vtle_pkg::JOB_REJECT : vtle_pkg::JOB_FIRST;
		end else begin
			q_job.kind = line_open ? vtle_pkg::JOB_NEXT : vtle_pkg::JOB_REJECT;
		end
	end

	// cursor and remaining points
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			remain_q   <= '0;
		end else if (q_push) begin
			if (first_point && !bad_count) begin
				cursor_x_q <= point_x;
				cursor_y_q <= point_y;
				remain_q   <= count_m1_w[CntW-1:0];
			end else if (!first_point && line_open) begin
				cursor_x_q <= point_x;
				cursor_y_q <= point_y;
				remain_q   <= remain_q - CntW'(1);
			end else begin
				cursor_x_q <= base_x;
				cursor_y_q <= base_y;
				if (first_point) begin
					remain_q <= '0;
				end
			end
		end
	end

endmodule

// ----- design/vtle_queue.sv -----
// ----------------------------------------------------------------------------
// vtle_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module vtle_queue #(
	parameter int unsigned DEPTH = vtle_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  vtle_pkg::job_t   push_job,
	output logic             full,
	input  logic             pop,
	output vtle_pkg::job_t   head_job,
	output logic             empty
);

	localparam int unsigned PtrW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	vtle_pkg::job_t  slot_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- design/vtle_back.sv -----
// ----------------------------------------------------------------------------
// vtle_back
// serializes each queued request into its geometry words through an
// output register
// ----------------------------------------------------------------------------
module vtle_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vtle_pkg::job_t              head_job,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vtle_pkg::WordW-1:0]  out_word,
	output logic                        out_last,
	output logic                        out_rej
);

	logic [1:0]                 idx_q;
	logic                       valid_q, last_q, rej_q;
	logic [vtle_pkg::WordW-1:0] word_q;

	logic                       load, take, last_word, rej_word;
	logic [vtle_pkg::WordW-1:0] word;

	assign load  = !valid_q || out_ready;
	assign take  = load && !q_empty;
	assign q_pop = take && last_word;

	// word selection for the current request and position
	always_comb begin
		word      = '0;
		last_word = 1'b1;
		rej_word  = 1'b0;
		unique case (head_job.kind)
			vtle_pkg::JOB_FIRST: begin
				unique case (idx_q)
					2'd0: word = vtle_pkg::CmdMoveToOne;
					2'd1: word = head_job.dx_zz;
					2'd2: word = head_job.dy_zz;
					default: word = {12'd0, head_job.run, vtle_pkg::HdrLineTo};
				endcase
				last_word = (idx_q == 2'd3);
			end
			vtle_pkg::JOB_NEXT: begin
				word      = (idx_q == 2'd0) ? head_job.dx_zz : head_job.dy_zz;
				last_word = (idx_q == 2'd1);
			end
			default: begin
				rej_word = 1'b1;
			end
		endcase
	end

	// position within the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= last_word ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= !q_empty;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			word_q <= word;
			last_q <= last_word;
			rej_q  <= rej_word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;
	assign out_last  = last_q;
	assign out_rej   = rej_q;

endmodule
